// ===== hdl/cft_pkg.sv =====
`timescale 1ns / 1ps
// cft_pkg: shared types and constants for the command forward tracker.
// No dependencies; used by cft_ctrl, cft_datapath and command_forward_tracker_top.
package cft_pkg;

	// pending table depth is kept a power of two so the slot is the low tag bits
	localparam int PEND_LOG2   = 8;
	localparam int PEND_DEPTH  = 1 << PEND_LOG2;
	localparam int PAW         = PEND_LOG2;

	localparam int QUEUE_DEPTH = 256;
	localparam int QAW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	// largest ring capacity exponent that still fits the ring storage
	localparam int QLOG_MAX    = $clog2(QUEUE_DEPTH + 1) - 1;

	// operation codes
	localparam logic [1:0] OP_FORWARD = 2'd0;
	localparam logic [1:0] OP_TAKE    = 2'd1;
	localparam logic [1:0] OP_DRAIN   = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NOT_READY   = 3'd1;
	localparam logic [2:0] ST_SLOT_BUSY   = 3'd2;
	localparam logic [2:0] ST_QUEUE_FULL  = 3'd3;
	localparam logic [2:0] ST_NO_MATCH    = 3'd4;
	localparam logic [2:0] ST_QUEUE_EMPTY = 3'd5;

	// configuration register indexes
	localparam int         CFG_IW      = 1;
	localparam int         CFG_DW      = 4;
	localparam logic [0:0] CFG_ENABLE  = 1'd0;
	localparam logic [0:0] CFG_QSIZE   = 1'd1;
	localparam logic [3:0] QSIZE_RESET = 4'd8;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] sub_queue_id;
		logic [15:0] comp_queue_id;
		logic [31:0] sq_entry_index;
		logic [15:0] command_id;
		logic [63:0] node_arg;
		logic [31:0] row_count;
		logic [31:0] row_size;
		logic [63:0] dest_address;
		logic [15:0] cmd_flags;
		logic [63:0] lookup_tag;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] tag_out;
		logic [15:0] sub_queue_out;
		logic [15:0] comp_queue_out;
		logic [31:0] entry_index_out;
		logic [15:0] command_out;
		logic [63:0] node_out;
		logic [31:0] rows_out;
		logic [31:0] row_size_out;
		logic [63:0] dest_out;
		logic [15:0] flags_out;
	} rsp_t;

	typedef struct packed {
		logic [63:0] tag;
		logic [31:0] entry_index;
		logic [15:0] sub_queue;
		logic [15:0] comp_queue;
		logic [15:0] command;
	} pend_entry_t;

	typedef struct packed {
		logic [63:0] tag;
		logic [63:0] node;
		logic [63:0] dest;
		logic [31:0] rows;
		logic [31:0] row_size;
		logic [15:0] sub_queue;
		logic [15:0] command;
		logic [15:0] flags;
	} desc_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch the transaction and launch table/ring reads
		logic execute;   // decide, update state, register the result
	} ctrl_cmd_t;

endpackage

// ===== hdl/command_forward_tracker_top.sv =====
`timescale 1ns / 1ps
// command_forward_tracker_top: forwards commands, tracks pending tags, drains the ring.
// Depends on cft_pkg, cft_ctrl and cft_datapath.
//
//  channel   | ports                          | transfer
//  ----------+--------------------------------+-----------------------------------
//  request   | start, busy, request           | edge with start high and busy low
//  result    | done, result                   | one-cycle strobe, always taken
//  config    | cfg_wr_en, cfg_index, cfg_data | edge with cfg_wr_en high
//
// Each transaction is latched with reads of the pending table and descriptor
// ring when accepted, then decided and applied in the execute state. done is
// high in the cycle after that; a new transaction may start in that same cycle.
// Reset clears the tag counter, ring pointers and pending busy marks, and resets the
// config registers; no clearing pass is needed. The result side cannot stall.
module command_forward_tracker_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  cft_pkg::req_t              request,
	output logic                       done,
	output cft_pkg::rsp_t              result,
	input  logic                       cfg_wr_en,
	input  logic [cft_pkg::CFG_IW-1:0] cfg_index,
	input  logic [cft_pkg::CFG_DW-1:0] cfg_data
);

	cft_pkg::ctrl_cmd_t cmd;

	cft_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	cft_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.request   (request),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule

// ===== hdl/cft_ctrl.sv =====
`timescale 1ns / 1ps
// cft_ctrl: two-state sequencer for the command forward tracker.
// Depends on cft_pkg (ctrl_cmd_t).
module cft_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output cft_pkg::ctrl_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.execute = 1'b1;
				state_d     = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.execute;
		end
	end

	assign busy = (state_q == ST_EXEC);
	assign done = done_q;

endmodule

// ===== hdl/cft_datapath.sv =====
`timescale 1ns / 1ps
// cft_datapath: tag counter, ring pointers, pending table, descriptor ring,
// configuration registers and result register. Depends on cft_pkg.
module cft_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cft_pkg::ctrl_cmd_t              cmd,
	input  cft_pkg::req_t                   request,
	input  logic                            cfg_wr_en,
	input  logic [cft_pkg::CFG_IW-1:0]      cfg_index,
	input  logic [cft_pkg::CFG_DW-1:0]      cfg_data,
	output cft_pkg::rsp_t                   result
);

	// configuration
	logic       enable_q;
	logic [3:0] qsize_log2_q;

	// control state
	logic [63:0] next_tag_q;
	logic [31:0] head_q;
	logic [31:0] tail_q;
	logic        pend_busy_q [cft_pkg::PEND_DEPTH];

	// transaction registers
	cft_pkg::req_t            req_q;
	logic [cft_pkg::PAW-1:0]  pslot_q;
	cft_pkg::pend_entry_t     pend_rd_q;
	cft_pkg::desc_t           ring_rd_q;
	cft_pkg::rsp_t            rsp_q;

	// storage
	cft_pkg::pend_entry_t pend_mem [cft_pkg::PEND_DEPTH];
	cft_pkg::desc_t       ring_mem [cft_pkg::QUEUE_DEPTH];

	logic [3:0]              cap_log2;
	logic [31:0]             cap;
	logic [31:0]             fill;
	logic [cft_pkg::QAW-1:0] ring_mask;
	logic [cft_pkg::QAW-1:0] head_slot;
	logic [cft_pkg::QAW-1:0] tail_slot;
	logic [cft_pkg::PAW-1:0] pslot_d;
	logic                    slot_busy;
	logic                    fwd_ok;
	logic                    take_ok;
	logic                    drain_ok;
	cft_pkg::rsp_t           rsp_d;
	cft_pkg::pend_entry_t    pend_wr;
	cft_pkg::desc_t          desc_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			qsize_log2_q <= cft_pkg::QSIZE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				cft_pkg::CFG_ENABLE: enable_q     <= cfg_data[0];
				cft_pkg::CFG_QSIZE:  qsize_log2_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// capacity is 2^qsize, clipped to the ring storage
	always_comb begin
		if (32'(qsize_log2_q) > 32'(cft_pkg::QLOG_MAX))
			cap_log2 = 4'(cft_pkg::QLOG_MAX);
		else
			cap_log2 = qsize_log2_q;
	end
	assign cap       = 32'd1 << cap_log2;
	assign ring_mask = cft_pkg::QAW'(cap - 32'd1);
	assign head_slot = head_q[cft_pkg::QAW-1:0] & ring_mask;
	assign tail_slot = tail_q[cft_pkg::QAW-1:0] & ring_mask;
	assign fill      = head_q - tail_q;

	assign pslot_d = (request.operation == cft_pkg::OP_TAKE) ?
		request.lookup_tag[cft_pkg::PAW-1:0] : next_tag_q[cft_pkg::PAW-1:0];

	// capture: latch the transaction and read both stores at the chosen slots
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q     <= request;
			pslot_q   <= pslot_d;
			pend_rd_q <= pend_mem[pslot_d];
			ring_rd_q <= ring_mem[tail_slot];
		end
	end

	assign slot_busy = pend_busy_q[pslot_q];

	always_comb begin
		rsp_d    = '0;
		fwd_ok   = 1'b0;
		take_ok  = 1'b0;
		drain_ok = 1'b0;
		case (req_q.operation)
			cft_pkg::OP_FORWARD: begin
				rsp_d.tag_out = next_tag_q;
				if (!enable_q)
					rsp_d.status = cft_pkg::ST_NOT_READY;
				else if (slot_busy)
					rsp_d.status = cft_pkg::ST_SLOT_BUSY;
				else if (fill >= cap)
					rsp_d.status = cft_pkg::ST_QUEUE_FULL;
				else begin
					rsp_d.status = cft_pkg::ST_OK;
					fwd_ok       = 1'b1;
				end
			end
			cft_pkg::OP_TAKE: begin
				if (slot_busy && pend_rd_q.tag == req_q.lookup_tag) begin
					take_ok               = 1'b1;
					rsp_d.status          = cft_pkg::ST_OK;
					rsp_d.tag_out         = req_q.lookup_tag;
					rsp_d.sub_queue_out   = pend_rd_q.sub_queue;
					rsp_d.comp_queue_out  = pend_rd_q.comp_queue;
					rsp_d.entry_index_out = pend_rd_q.entry_index;
					rsp_d.command_out     = pend_rd_q.command;
				end else begin
					rsp_d.status = cft_pkg::ST_NO_MATCH;
				end
			end
			cft_pkg::OP_DRAIN: begin
				if (head_q == tail_q) begin
					rsp_d.status = cft_pkg::ST_QUEUE_EMPTY;
				end else begin
					drain_ok            = 1'b1;
					rsp_d.status        = cft_pkg::ST_OK;
					rsp_d.tag_out       = ring_rd_q.tag;
					rsp_d.sub_queue_out = ring_rd_q.sub_queue;
					rsp_d.command_out   = ring_rd_q.command;
					rsp_d.node_out      = ring_rd_q.node;
					rsp_d.rows_out      = ring_rd_q.rows;
					rsp_d.row_size_out  = ring_rd_q.row_size;
					rsp_d.dest_out      = ring_rd_q.dest;
					rsp_d.flags_out     = ring_rd_q.flags;
				end
			end
			default: rsp_d.status = cft_pkg::ST_NO_MATCH;
		endcase
	end

	always_comb begin
		pend_wr.tag         = next_tag_q;
		pend_wr.entry_index = req_q.sq_entry_index;
		pend_wr.sub_queue   = req_q.sub_queue_id;
		pend_wr.comp_queue  = req_q.comp_queue_id;
		pend_wr.command     = req_q.command_id;

		desc_wr.tag       = next_tag_q;
		desc_wr.node      = req_q.node_arg;
		desc_wr.dest      = req_q.dest_address;
		desc_wr.rows      = req_q.row_count;
		desc_wr.row_size  = req_q.row_size;
		desc_wr.sub_queue = req_q.sub_queue_id;
		desc_wr.command   = req_q.command_id;
		desc_wr.flags     = req_q.cmd_flags;
	end

	always_ff @(posedge clk) begin
		if (cmd.execute && fwd_ok) begin
			pend_mem[pslot_q]   <= pend_wr;
			ring_mem[head_slot] <= desc_wr;
		end
		if (cmd.execute)
			rsp_q <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_tag_q <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			for (int i = 0; i < cft_pkg::PEND_DEPTH; i++)
				pend_busy_q[i] <= 1'b0;
		end else if (cmd.execute) begin
			if (fwd_ok) begin
				next_tag_q           <= next_tag_q + 64'd1;
				head_q               <= head_q + 32'd1;
				pend_busy_q[pslot_q] <= 1'b1;
			end
			if (take_ok)
				pend_busy_q[pslot_q] <= 1'b0;
			if (drain_ok)
				tail_q <= tail_q + 32'd1;
		end
	end

	assign result = rsp_q;

endmodule

// ===== test/cft_checker.sv =====
`timescale 1ns / 1ps
// cft_checker: predicts command_forward_tracker_top results and compares them.
// Watches the request, result and config channels; depends on cft_pkg.
module cft_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  cft_pkg::req_t              request,
	input  logic                       done,
	input  cft_pkg::rsp_t              result,
	input  logic                       cfg_wr_en,
	input  logic [cft_pkg::CFG_IW-1:0] cfg_index,
	input  logic [cft_pkg::CFG_DW-1:0] cfg_data,
	output int                         fail_count,
	output int                         outstanding
);
	import cft_pkg::*;

	// shadow of the tracker state
	logic [63:0]           tag_ctr;
	logic [31:0]           head_ptr;
	logic [31:0]           tail_ptr;
	desc_t                 ring_mem [QUEUE_DEPTH];
	pend_entry_t           pend_mem [PEND_DEPTH];
	logic [PEND_DEPTH-1:0] pend_live;
	logic                  en_r;
	logic [3:0]            qlog_r;

	rsp_t awaited_rsp [$];

	function automatic rsp_t apply_command(input req_t c);
		rsp_t           r;
		logic [31:0]    cap;
		logic [31:0]    slot32;
		logic [PAW-1:0] ps;
		logic [QAW-1:0] rs;
		r = '0;
		// capacity is clamped to the ring storage
		cap = 32'd1 << qlog_r;
		while (cap > QUEUE_DEPTH)
			cap = cap >> 1;
		case (c.operation)
			OP_FORWARD: begin
				ps = tag_ctr[PAW-1:0];
				r.tag_out = tag_ctr;
				if (!en_r) begin
					r.status = ST_NOT_READY;
				end else if (pend_live[ps]) begin
					r.status = ST_SLOT_BUSY;
				end else if (head_ptr - tail_ptr >= cap) begin
					r.status = ST_QUEUE_FULL;
				end else begin
					slot32 = head_ptr & (cap - 32'd1);
					rs = slot32[QAW-1:0];
					ring_mem[rs] = '{tag: tag_ctr, node: c.node_arg, dest: c.dest_address,
						rows: c.row_count, row_size: c.row_size, sub_queue: c.sub_queue_id,
						command: c.command_id, flags: c.cmd_flags};
					head_ptr = head_ptr + 32'd1;
					pend_mem[ps] = '{tag: tag_ctr, entry_index: c.sq_entry_index,
						sub_queue: c.sub_queue_id, comp_queue: c.comp_queue_id,
						command: c.command_id};
					pend_live[ps] = 1'b1;
					tag_ctr = tag_ctr + 64'd1;
					r.status = ST_OK;
				end
			end
			OP_TAKE: begin
				ps = c.lookup_tag[PAW-1:0];
				if (pend_live[ps] && pend_mem[ps].tag == c.lookup_tag) begin
					r.status = ST_OK;
					r.tag_out = c.lookup_tag;
					r.sub_queue_out = pend_mem[ps].sub_queue;
					r.comp_queue_out = pend_mem[ps].comp_queue;
					r.entry_index_out = pend_mem[ps].entry_index;
					r.command_out = pend_mem[ps].command;
					pend_live[ps] = 1'b0;
				end else begin
					r.status = ST_NO_MATCH;
				end
			end
			OP_DRAIN: begin
				if (head_ptr == tail_ptr) begin
					r.status = ST_QUEUE_EMPTY;
				end else begin
					slot32 = tail_ptr & (cap - 32'd1);
					rs = slot32[QAW-1:0];
					r.status = ST_OK;
					r.tag_out = ring_mem[rs].tag;
					r.sub_queue_out = ring_mem[rs].sub_queue;
					r.command_out = ring_mem[rs].command;
					r.node_out = ring_mem[rs].node;
					r.rows_out = ring_mem[rs].rows;
					r.row_size_out = ring_mem[rs].row_size;
					r.dest_out = ring_mem[rs].dest;
					r.flags_out = ring_mem[rs].flags;
					tail_ptr = tail_ptr + 32'd1;
				end
			end
			default: begin
				r.status = ST_NO_MATCH;
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h actual %h", $time, fname, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : watch
		rsp_t want;
		if (!arst_n) begin
			tag_ctr = '0;
			head_ptr = '0;
			tail_ptr = '0;
			pend_live = '0;
			en_r = 1'b0;
			qlog_r = QSIZE_RESET;
			awaited_rsp.delete();
			fail_count = 0;
		end else begin
			// compare before queueing this edge's transaction
			if (done) begin
				if (awaited_rsp.size() == 0) begin
					$display("%0t: unexpected result: expected none actual %h", $time, result);
					fail_count++;
				end else begin
					want = awaited_rsp.pop_front();
					check_field("status", 64'(want.status), 64'(result.status));
					check_field("tag_out", want.tag_out, result.tag_out);
					check_field("sub_queue_out", 64'(want.sub_queue_out),
						64'(result.sub_queue_out));
					check_field("comp_queue_out", 64'(want.comp_queue_out),
						64'(result.comp_queue_out));
					check_field("entry_index_out", 64'(want.entry_index_out),
						64'(result.entry_index_out));
					check_field("command_out", 64'(want.command_out),
						64'(result.command_out));
					check_field("node_out", want.node_out, result.node_out);
					check_field("rows_out", 64'(want.rows_out), 64'(result.rows_out));
					check_field("row_size_out", 64'(want.row_size_out),
						64'(result.row_size_out));
					check_field("dest_out", want.dest_out, result.dest_out);
					check_field("flags_out", 64'(want.flags_out), 64'(result.flags_out));
				end
			end
			if (cfg_wr_en) begin
				if (cfg_index == CFG_ENABLE)
					en_r = cfg_data[0];
				else if (cfg_index == CFG_QSIZE)
					qlog_r = cfg_data;
			end
			if (start && !busy)
				awaited_rsp.push_back(apply_command(request));
		end
		outstanding = awaited_rsp.size();
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for command_forward_tracker_top.
// Depends on cft_pkg, the RTL and cft_checker.
module tb_top;
	import cft_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         STALL_LIMIT = 1000;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	req_t                request;
	logic                done;
	rsp_t                result;
	logic                cfg_wr_en;
	logic [CFG_IW-1:0]   cfg_index;
	logic [CFG_DW-1:0]   cfg_data;
	int                  fail_count;
	int                  outstanding;
	int                  idle_pct;
	int                  stall_cycles = 0;

	logic [1:0]  issued_ops [$];
	logic [63:0] live_tags [$];   // tags believed to hold a busy pending slot, oldest first

	command_forward_tracker_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	cft_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// follow live tags from the result stream so takes can aim at real entries
	always @(posedge clk) begin : track
		logic [1:0] op;
		int         i;
		if (!arst_n) begin
			issued_ops.delete();
			live_tags.delete();
		end else begin
			if (done && issued_ops.size() > 0) begin
				op = issued_ops.pop_front();
				if (result.status == ST_OK && op == OP_FORWARD) begin
					live_tags.push_back(result.tag_out);
				end else if (result.status == ST_OK && op == OP_TAKE) begin
					for (i = 0; i < live_tags.size(); i++) begin
						if (live_tags[i] == result.tag_out) begin
							live_tags.delete(i);
							break;
						end
					end
				end
			end
			if (start && !busy)
				issued_ops.push_back(request.operation);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_wr_en)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic req_t random_cmd(input logic [1:0] op);
		req_t rq;
		case ($urandom_range(0, 19))
			0: rq = '0;
			1: rq = '1;
			default: begin
				rq.sub_queue_id = 16'($urandom);
				rq.comp_queue_id = 16'($urandom);
				rq.sq_entry_index = $urandom;
				rq.command_id = 16'($urandom);
				rq.node_arg = {$urandom, $urandom};
				rq.row_count = $urandom;
				rq.row_size = $urandom;
				rq.dest_address = {$urandom, $urandom};
				rq.cmd_flags = 16'($urandom);
				rq.lookup_tag = {$urandom, $urandom};
			end
		endcase
		rq.operation = op;
		return rq;
	endfunction

	// mostly well-formed traffic: takes favor the oldest tag, which frees the
	// slot the next forward needs
	function automatic req_t pick_cmd();
		req_t rq;
		int   r;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			rq = random_cmd(OP_FORWARD);
		end else if (r < 70) begin
			rq = random_cmd(OP_TAKE);
			r = $urandom_range(0, 9);
			if (live_tags.size() > 0) begin
				if (r < 6)
					rq.lookup_tag = live_tags[0];
				else if (r < 8)
					rq.lookup_tag = live_tags[$urandom_range(0, live_tags.size() - 1)];
				else if (r < 9)
					rq.lookup_tag = live_tags[0] ^ (64'd1 << $urandom_range(8, 63));
			end
		end else if (r < 95) begin
			rq = random_cmd(OP_DRAIN);
		end else begin
			rq = random_cmd(OP_UNUSED);
		end
		return rq;
	endfunction

	task automatic issue(input req_t rq);
		while ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		request = rq;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic issue_take(input logic [63:0] tag);
		req_t rq;
		rq = random_cmd(OP_TAKE);
		rq.lookup_tag = tag;
		issue(rq);
	endtask

	task automatic settle();
		start = 1'b0;
		@(negedge clk);
		while (outstanding != 0 || busy)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	initial begin
		req_t rq;
		int   sub;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// disabled after reset: forward refused, take and drain still answer
		rq = '1;
		rq.operation = OP_FORWARD;
		issue(rq);
		issue_take(64'd0);
		issue(random_cmd(OP_DRAIN));
		issue('1);

		// single-entry ring
		settle();
		write_reg(CFG_ENABLE, 4'hF);
		write_reg(CFG_QSIZE, 4'd0);
		issue('0);
		rq = '1;
		rq.operation = OP_FORWARD;
		issue(rq);
		issue(random_cmd(OP_DRAIN));
		issue(random_cmd(OP_DRAIN));

		settle();
		write_reg(CFG_QSIZE, QSIZE_RESET);
		issue(rq);
		issue(random_cmd(OP_FORWARD));
		rq = '1;
		rq.operation = OP_TAKE;
		issue(rq);
		issue_take(64'd1);
		issue_take(64'd1);
		issue_take(64'd258);   // same slot as tag 2, different tag
		issue(random_cmd(OP_DRAIN));
		issue(random_cmd(OP_DRAIN));
		issue(random_cmd(OP_DRAIN));

		settle();
		write_reg(CFG_ENABLE, 4'hE);
		issue(random_cmd(OP_FORWARD));
		issue_take(64'd2);
		settle();
		write_reg(CFG_ENABLE, 4'h1);

		// forward until the pending table hits a busy slot, free it, then run the ring dry
		idle_pct = 11;
		repeat (PEND_DEPTH) issue(random_cmd(OP_FORWARD));
		issue(random_cmd(OP_FORWARD));
		settle();
		issue_take(live_tags[0]);
		issue(random_cmd(OP_FORWARD));
		repeat (QUEUE_DEPTH + 1) issue(random_cmd(OP_DRAIN));

		// capacity changes land between bursts of mixed traffic; the ring may still hold entries
		for (sub = 0; sub < 6; sub++) begin
			settle();
			write_reg(CFG_ENABLE, {3'($urandom), 1'(sub != 3)});
			case (sub)
				0: write_reg(CFG_QSIZE, 4'd2);
				1: write_reg(CFG_QSIZE, 4'd15);
				2: write_reg(CFG_QSIZE, 4'd0);
				3: write_reg(CFG_QSIZE, 4'd4);
				4: write_reg(CFG_QSIZE, 4'd5);
				default: write_reg(CFG_QSIZE, 4'd8);
			endcase
			idle_pct = (sub < 2) ? 11 : (sub < 4) ? 67 : 0;
			repeat (70) begin
				if ($urandom_range(0, 49) == 0)
					settle();
				issue(pick_cmd());
			end
		end

		settle();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== command_forward_tracker_top.f =====
hdl/cft_pkg.sv
hdl/cft_ctrl.sv
hdl/cft_datapath.sv
hdl/command_forward_tracker_top.sv
test/cft_checker.sv
test/tb_top.sv
